// ===== hw/rtl/lbvh_ss_pkg.sv =====
// Shared types, constants and helper functions for the LBVH split search block.
// No dependencies; imported by every module of the block but the checker.
package lbvh_ss_pkg;

    localparam int CODE_DEPTH = 1024;
    localparam int IDX_W      = 10;
    localparam int CODE_W     = 64;
    localparam int ADDR_W     = $clog2(CODE_DEPTH);

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ_LAST,
        ST_PREP,
        ST_SEARCH,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CODE_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    function automatic logic in_range(input logic [IDX_W-1:0] idx);
        return (32'(idx) < 32'(CODE_DEPTH));
    endfunction

    function automatic logic [ADDR_W-1:0] to_addr(input logic [IDX_W-1:0] idx);
        return ADDR_W'(idx);
    endfunction

    // mark every bit at or above the highest set bit of d
    function automatic logic [CODE_W-1:0] top_mask(input logic [CODE_W-1:0] d);
        logic [CODE_W-1:0] p;
        p = d;
        p = p | (p >> 1);
        p = p | (p >> 2);
        p = p | (p >> 4);
        p = p | (p >> 8);
        p = p | (p >> 16);
        p = p | (p >> 32);
        return ~(p >> 1);
    endfunction

endpackage

// ===== hw/rtl/lbvh_ss_code_ram.sv =====
// Code store: single-port-write, single-port-read synchronous RAM with registered read data.
// Depends on lbvh_ss_pkg for depth, widths and the request struct.
module lbvh_ss_code_ram
    import lbvh_ss_pkg::*;
(
    input  logic              aclk,
    input  ram_req_t          req,
    output logic [CODE_W-1:0] rdata
);

    logic [CODE_W-1:0] mem [CODE_DEPTH];
    logic [CODE_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re) begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/lbvh_ss_search_ctl.sv =====
// Sequencer and datapath of the split search: issues store reads and walks the halving steps.
// Depends on lbvh_ss_pkg; drives the request port of lbvh_ss_code_ram.
module lbvh_ss_search_ctl
    import lbvh_ss_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  opcode_t           opcode,
    input  logic [IDX_W-1:0]  slot,
    input  logic [CODE_W-1:0] code_value,
    input  logic [IDX_W-1:0]  first_index,
    input  logic [IDX_W-1:0]  last_index,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [IDX_W-1:0]  split_index,
    output ram_req_t          ram_req,
    input  logic [CODE_W-1:0] ram_rdata
);

    state_t            state_reg, state_next;
    logic [CODE_W-1:0] lo_code_reg, lo_code_next;
    logic [CODE_W-1:0] mask_reg, mask_next;
    logic [IDX_W-1:0]  first_reg, first_next;
    logic [IDX_W-1:0]  last_reg, last_next;
    logic [IDX_W-1:0]  pos_reg, pos_next;
    logic [IDX_W-1:0]  stride_reg, stride_next;
    logic [IDX_W-1:0]  trial_reg, trial_next;
    logic              pend_reg, pend_next;
    logic              rd_zero_reg, rd_zero_next;
    logic [IDX_W-1:0]  result_reg, result_next;
    logic              out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]  out_data_reg, out_data_next;

    logic [CODE_W-1:0] data_eff;
    logic              hit;
    logic [IDX_W-1:0]  pos_eff;
    logic [IDX_W-1:0]  stride_n;
    logic [IDX_W:0]    trial_n;
    logic              out_free;
    logic              accept;

    assign data_eff = rd_zero_reg ? '0 : ram_rdata;
    assign hit      = (((lo_code_reg ^ data_eff) & mask_reg) == '0);
    assign pos_eff  = (pend_reg && hit) ? trial_reg : pos_reg;
    assign stride_n = IDX_W'(({1'b0, stride_reg} + (IDX_W+1)'(1)) >> 1);
    assign trial_n  = {1'b0, pos_eff} + {1'b0, stride_n};
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            rd_zero_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
            rd_zero_reg   <= rd_zero_next;
        end
        lo_code_reg  <= lo_code_next;
        mask_reg     <= mask_next;
        first_reg    <= first_next;
        last_reg     <= last_next;
        pos_reg      <= pos_next;
        stride_reg   <= stride_next;
        trial_reg    <= trial_next;
        result_reg   <= result_next;
        out_data_reg <= out_data_next;
    end

    always_comb begin
        state_next     = state_reg;
        lo_code_next   = lo_code_reg;
        mask_next      = mask_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        pos_next       = pos_reg;
        stride_next    = stride_reg;
        trial_next     = trial_reg;
        pend_next      = pend_reg;
        rd_zero_next   = rd_zero_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        ram_req        = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (opcode == OP_WRITE) begin
                        ram_req.we    = in_range(slot);
                        ram_req.waddr = to_addr(slot);
                        ram_req.wdata = code_value;
                    end else begin
                        first_next = first_index;
                        last_next  = last_index;
                        if (last_index < first_index) begin
                            result_next = first_index;
                            state_next  = ST_DONE;
                        end else begin
                            ram_req.re    = 1'b1;
                            ram_req.raddr = to_addr(first_index);
                            rd_zero_next  = !in_range(first_index);
                            state_next    = ST_READ_LAST;
                        end
                    end
                end
            end
            ST_READ_LAST: begin
                lo_code_next  = data_eff;
                ram_req.re    = 1'b1;
                ram_req.raddr = to_addr(last_reg);
                rd_zero_next  = !in_range(last_reg);
                state_next    = ST_PREP;
            end
            ST_PREP: begin
                if (data_eff == lo_code_reg) begin
                    result_next = IDX_W'(({1'b0, first_reg} + {1'b0, last_reg}) >> 1);
                    state_next  = ST_DONE;
                end else begin
                    mask_next   = top_mask(lo_code_reg ^ data_eff);
                    pos_next    = first_reg;
                    stride_next = last_reg - first_reg;
                    pend_next   = 1'b0;
                    state_next  = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                pos_next  = pos_eff;
                pend_next = 1'b0;
                if (stride_reg <= IDX_W'(1)) begin
                    result_next = pos_eff;
                    state_next  = ST_DONE;
                end else begin
                    stride_next = stride_n;
                    trial_next  = IDX_W'(trial_n);
                    if (trial_n < {1'b0, last_reg}) begin
                        pend_next     = 1'b1;
                        ram_req.re    = 1'b1;
                        ram_req.raddr = to_addr(IDX_W'(trial_n));
                        rd_zero_next  = !in_range(IDX_W'(trial_n));
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = result_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign split_index = out_data_reg;

endmodule

// ===== hw/rtl/lbvh_split_search_top.sv =====
// Write word: taken while idle, no result. Query word: a reversed range gives first_index with no
// store read, equal end codes give the midpoint, otherwise the search walks halving steps;
// a halving step reads the code store's single read port only when its trial index lies below
// last_index. One query in flight; the next word is taken once the result is in the output register.
// Reset (aresetn low, synchronous) clears control state; the code store is undefined until written.
module lbvh_split_search_top
    import lbvh_ss_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // slot[9:0], code_value[73:10], first_index[83:74],
                                   // last_index[93:84], zero fill[95:94]
    input  logic        s_tuser,   // opcode[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // split_index[9:0], zero fill[15:10]
);

    ram_req_t          ram_req;
    logic [CODE_W-1:0] ram_rdata;
    logic [IDX_W-1:0]  split_index;

    lbvh_ss_search_ctl u_ctl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .opcode      (opcode_t'(s_tuser)),
        .slot        (s_tdata[9:0]),
        .code_value  (s_tdata[73:10]),
        .first_index (s_tdata[83:74]),
        .last_index  (s_tdata[93:84]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .split_index (split_index),
        .ram_req     (ram_req),
        .ram_rdata   (ram_rdata)
    );

    lbvh_ss_code_ram u_ram (
        .aclk  (aclk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    assign m_tdata = {6'd0, split_index};

endmodule

// ===== hw/rtl/lbvh_ss_checker.sv =====
// Port-level checks for lbvh_split_search_top, attached by the bind below.
// Depends only on the top level's ports.
module lbvh_ss_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [95:0] s_tdata,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    logic s_acc;
    assign s_acc = s_tvalid && s_tready;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_write_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && !s_tuser |=> !$rose(m_tvalid))
        else $error("write word produced a result");

    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && s_tuser |=> !s_tready)
        else $error("new word taken while a query is in progress");

    a_out_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:10] == 6'd0)
        else $error("result fill bits not zero");

endmodule

bind lbvh_split_search_top lbvh_ss_checker u_chk (.*);

// ===== dv/tb_lbvh_split_search_top.sv =====
// Testbench for lbvh_split_search_top: sorted Morton code runs are written into the store,
// then split queries, most over written ranges, are checked by an in-bench predictor.
// Depends on lbvh_ss_pkg (opcode_t) and the lbvh_split_search_top RTL only.
module tb_lbvh_split_search_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lbvh_ss_pkg::*;

    localparam int NUM_WORDS = 1350;
    localparam int HOLD_AT   = 40;
    localparam int HOLD_LEN  = 400;

    typedef struct {
        opcode_t     op;
        logic [9:0]  slot;
        logic [63:0] code;
        logic [9:0]  first_idx;
        logic [9:0]  last_idx;
        int          phase;
    } stim_word_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    stim_word_t  word_q[$];
    stim_word_t  cur_word;
    logic [9:0]  pending_splits[$];
    logic [63:0] code_mem[1024];
    bit          gen_written[1024];
    int          gen_count;
    int          gen_phase;
    int          rx_phase = 0;
    int          results_seen = 0;
    int          hold_left = 0;
    bit          hold_done = 0;
    int          error_count = 0;

    lbvh_split_search_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 aclk = ~aclk;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic int lead_zero_count(input logic [63:0] v);
        int n;
        n = 0;
        for (int b = 63; b >= 0; b--) begin
            if (v[b])
                break;
            n++;
        end
        return n;
    endfunction

    function automatic logic [9:0] find_split_index(input int lo, input int hi);
        logic [63:0] lo_code;
        logic [63:0] hi_code;
        int          shared;
        int          pos;
        int          stride;
        int          trial;
        if (hi < lo)
            return lo[9:0];
        lo_code = code_mem[lo];
        hi_code = code_mem[hi];
        if (lo_code == hi_code)
            return 10'((lo + hi) >> 1);
        shared = lead_zero_count(lo_code ^ hi_code);
        pos    = lo;
        stride = hi - lo;
        do begin
            stride = (stride + 1) >> 1;
            trial  = pos + stride;
            if (trial < hi && lead_zero_count(lo_code ^ code_mem[trial]) > shared)
                pos = trial;
        end while (stride > 1);
        return pos[9:0];
    endfunction

    function automatic int tx_idle_pct(input int ph);
        return (ph == 1) ? 82 : (ph == 3) ? 6 : 0;
    endfunction

    function automatic int rx_stall_pct(input int ph);
        return (ph == 2) ? 82 : (ph == 3) ? 6 : 0;
    endfunction

    task automatic add_write(input int slot, input logic [63:0] code);
        stim_word_t w;
        w.op        = OP_WRITE;
        w.slot      = slot[9:0];
        w.code      = code;
        w.first_idx = 10'($urandom);
        w.last_idx  = 10'($urandom);
        w.phase     = gen_phase;
        word_q.push_back(w);
        gen_written[slot] = 1'b1;
        gen_count++;
    endtask

    task automatic add_query(input int first_idx, input int last_idx);
        stim_word_t w;
        w.op        = OP_QUERY;
        w.slot      = 10'($urandom);
        w.code      = rand64();
        w.first_idx = first_idx[9:0];
        w.last_idx  = last_idx[9:0];
        w.phase     = gen_phase;
        word_q.push_back(w);
        gen_count++;
    endtask

    // stimulus
    initial begin
        int          len;
        int          base;
        int          lo;
        int          hi;
        int          fi;
        int          la;
        int          idx;
        logic [63:0] code;

        gen_count = 0;
        gen_phase = 0;
        foreach (code_mem[i])
            code_mem[i] = '0;

        add_write(0, 64'h0);
        add_write(1, 64'h0);
        add_write(2, 64'h1);
        add_write(3, 64'h3);
        add_write(4, 64'h8000_0000_0000_0000);
        add_write(5, 64'h8000_0000_0000_0001);
        add_write(6, 64'hFFFF_FFFF_FFFF_FFFE);
        add_write(7, 64'hFFFF_FFFF_FFFF_FFFF);
        add_write(1022, 64'hFFFF_FFFF_FFFF_FFFF);
        add_write(1023, 64'hFFFF_FFFF_FFFF_FFFF);
        add_query(0, 7);
        add_query(0, 1);
        add_query(2, 3);
        add_query(1023, 1023);
        add_query(1022, 1023);
        add_query(5, 2);
        add_query(1023, 0);
        add_query(4, 7);
        add_query(2, 6);
        add_query(0, 0);

        while (gen_count < NUM_WORDS) begin
            gen_phase = (gen_count * 4) / NUM_WORDS;
            if (gen_phase > 3)
                gen_phase = 3;
            case ($urandom_range(0, 99)) inside
                [0:54]: begin
                    len  = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 200)
                                                        : $urandom_range(2, 24);
                    base = $urandom_range(0, 1023);
                    if (base + len > 1024)
                        base = 1024 - len;
                    code = rand64() >> $urandom_range(0, 63);
                    for (int i = 0; i < len; i++) begin
                        add_write(base + i, code);
                        if ($urandom_range(0, 99) >= 15)
                            code = code + (rand64() >> $urandom_range(8, 63));
                    end
                    repeat ($urandom_range(1, 4)) begin
                        case ($urandom_range(0, 3))
                            0: begin
                                fi = base;
                                la = base + len - 1;
                            end
                            1: begin
                                fi = $urandom_range(base, base + len - 1);
                                la = $urandom_range(fi, base + len - 1);
                            end
                            2: begin
                                fi = $urandom_range(base, base + len - 1);
                                la = fi;
                            end
                            default: begin
                                la = $urandom_range(base, base + len - 2);
                                fi = $urandom_range(la + 1, base + len - 1);
                            end
                        endcase
                        add_query(fi, la);
                    end
                end
                [55:84]: begin
                    idx = $urandom_range(0, 1023);
                    if (gen_written[idx]) begin
                        lo = idx;
                        hi = idx;
                        while (lo > 0 && gen_written[lo-1])
                            lo--;
                        while (hi < 1023 && gen_written[hi+1])
                            hi++;
                        if ($urandom_range(0, 99) < 40) begin
                            fi = lo;
                            la = hi;
                        end else begin
                            fi = $urandom_range(lo, hi);
                            la = $urandom_range(fi, hi);
                        end
                        add_query(fi, la);
                    end
                end
                [85:92]: begin
                    fi = $urandom_range(1, 1023);
                    la = $urandom_range(0, fi - 1);
                    add_query(fi, la);
                end
                default: begin
                    case ($urandom_range(0, 3))
                        0:       code = 64'h0;
                        1:       code = 64'hFFFF_FFFF_FFFF_FFFF;
                        default: code = rand64();
                    endcase
                    add_write($urandom_range(0, 1023), code);
                end
            endcase
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        do
            @(negedge aclk);
        while (word_q.size() > 0 || s_tvalid || pending_splits.size() > 0);
        repeat (40) @(negedge aclk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("%0t: timeout, %0d words left, %0d splits pending", $time, word_q.size(),
                 pending_splits.size());
        $display("Test completed with failures");
        $finish;
    end

    // driver
    always @(posedge aclk) begin : word_driver
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (cur_word.op == OP_QUERY)
                    pending_splits.push_back(find_split_index(cur_word.first_idx,
                                                              cur_word.last_idx));
                else
                    code_mem[cur_word.slot] = cur_word.code;
            end
            if (!s_tvalid || s_tready) begin
                if (word_q.size() > 0 &&
                    $urandom_range(0, 99) >= tx_idle_pct(word_q[0].phase)) begin
                    cur_word = word_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {2'b00, cur_word.last_idx, cur_word.first_idx,
                                 cur_word.code, cur_word.slot};
                    s_tuser  <= cur_word.op;
                    rx_phase <= cur_word.phase;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin : split_monitor
        logic [9:0] want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (pending_splits.size() == 0) begin
                    $display("%0t: unexpected split_index, expected none, actual %0d",
                             $time, m_tdata[9:0]);
                    error_count++;
                end else begin
                    want = pending_splits.pop_front();
                    if (m_tdata[9:0] !== want) begin
                        $display("%0t: split_index mismatch, expected %0d, actual %0d",
                                 $time, want, m_tdata[9:0]);
                        error_count++;
                    end
                end
            end
            // hold off once for a long stretch so the input backs up
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (results_seen == HOLD_AT && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= rx_stall_pct(rx_phase));
            end
        end
    end

endmodule
